// ----- rtl/sapq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Holds the request and result payloads and the controller/datapath interface.
// No dependencies.
package sapq_pkg;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] tag;
        logic [3:0]  prio;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [3:0]  out_prio;
        logic [4:0]  occupancy;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       ins;
        logic       rem;
        logic       res_we;
        logic [1:0] status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
    } sts_t;

endpackage

// ----- rtl/sapq_datapath.sv -----
// Datapath of the sorted priority queue: request register, entry cell chain,
// held count and result register. Depends on sapq_pkg.
module sapq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  sapq_pkg::in_t   req,
    input  sapq_pkg::cmd_t  cmd,
    output sapq_pkg::sts_t  sts,
    output sapq_pkg::out_t  result
);
    import sapq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    in_t          req_reg;
    logic [15:0]  tag_reg  [DEPTH];
    logic [3:0]   prio_reg [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    out_t         result_reg;
    logic [DEPTH-1:0] ge;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req;
        end
    end

    // A cell stays put when it holds an entry of equal or higher priority.
    // Those cells form a prefix because the chain is sorted.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign ge[i] = (CW'(i) < count_reg) && (prio_reg[i] >= req_reg.prio);

        always_ff @(posedge aclk) begin
            if (cmd.ins && !ge[i]) begin
                if (i == 0) begin
                    tag_reg[i]  <= req_reg.tag;
                    prio_reg[i] <= req_reg.prio;
                end else if (ge[(i == 0) ? 0 : i - 1]) begin
                    tag_reg[i]  <= req_reg.tag;
                    prio_reg[i] <= req_reg.prio;
                end else begin
                    tag_reg[i]  <= tag_reg[(i == 0) ? 0 : i - 1];
                    prio_reg[i] <= prio_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (cmd.rem && (i < DEPTH - 1)) begin
                tag_reg[i]  <= tag_reg[(i < DEPTH - 1) ? i + 1 : i];
                prio_reg[i] <= prio_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_we) begin
            result_reg.status    <= cmd.status;
            result_reg.out_tag   <= cmd.rem ? tag_reg[0] : 16'd0;
            result_reg.out_prio  <= cmd.rem ? prio_reg[0] : 4'd0;
            result_reg.occupancy <= 5'(count_next);
        end
    end

    assign sts.kind  = req_reg.kind;
    assign sts.full  = (count_reg == CW'(DEPTH));
    assign sts.empty = (count_reg == '0);
    assign result    = result_reg;

endmodule

// ----- rtl/sapq_ctrl.sv -----
// Controller of the sorted priority queue: request handshake, update step
// and result valid. Depends on sapq_pkg.
module sapq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  sapq_pkg::sts_t  sts,
    output sapq_pkg::cmd_t  cmd
);
    import sapq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // A new request is taken only when the result register is free or is
    // being emptied in the same cycle.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.load     = s_valid && s_ready;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.res_we   = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
                if (sts.kind == KIND_INSERT) begin
                    if (sts.full) begin
                        cmd.status = STATUS_FULL;
                    end else begin
                        cmd.ins    = 1'b1;
                        cmd.status = STATUS_DONE;
                    end
                end else begin
                    if (sts.empty) begin
                        cmd.status = STATUS_EMPTY;
                    end else begin
                        cmd.rem    = 1'b1;
                        cmd.status = STATUS_DONE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: controller plus entry datapath.
// Depends on sapq_pkg, sapq_ctrl and sapq_datapath.
//
// A bounded queue of up to DEPTH entries kept sorted by priority, highest at
// the head; equal priorities leave in arrival order. Each request (insert or
// remove head) gives exactly one result with a status, the removed entry and
// the occupancy after the request. A request goes through the idle state, in
// which it is accepted, and the update state, in which every entry cell
// compares its priority with the new one at once and the chain shifts. The
// result then waits in an output register, and the next request is accepted
// in the cycle that result is taken. No clearing pass is needed after reset.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sapq_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sapq_pkg::out_t m_data
);
    import sapq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sapq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sapq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (m_data)
    );

endmodule
